// ===== design/stfl_pkg.sv =====
// -----------------------------------------------------------------------------
// stfl_pkg - shared definitions for the sparse three-flag tracker
// Geometry of the slot table and flag memory, request kinds and flag bits.
// -----------------------------------------------------------------------------
package stfl_pkg;

	// Geometry
	localparam int BYTES_PER_FLAG  = 4096;
	localparam int FLAGS_PER_GROUP = 1024;
	localparam int GROUP_SLOTS     = 16;

	localparam int INDEX_W = 64;
	localparam int FLAG_W  = 3;
	localparam int BYTE_SH = $clog2(BYTES_PER_FLAG);
	localparam int OFF_W   = $clog2(FLAGS_PER_GROUP);
	localparam int TAG_LSB = BYTE_SH + OFF_W;
	localparam int TAG_W   = INDEX_W - TAG_LSB;
	localparam int SLOT_W  = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
	localparam int POS_W   = SLOT_W + OFF_W;
	localparam int DEPTH   = GROUP_SLOTS * FLAGS_PER_GROUP;
	localparam int CNT_W   = $clog2(FLAGS_PER_GROUP + 1);

	// Stream widths
	localparam int KIND_W   = 2;
	localparam int IN_DATA_W  = ((INDEX_W + 2 * FLAG_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = 8;

	// Flag bits
	localparam logic [FLAG_W-1:0] FLAG_DONE     = 3'b001;
	localparam logic [FLAG_W-1:0] FLAG_RELEVANT = 3'b010;
	localparam logic [FLAG_W-1:0] FLAG_SEEN     = 3'b100;

	// Request kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_READ   = 2'd0,
		KIND_MODIFY = 2'd1,
		KIND_CHECK  = 2'd2
	} kind_t;

endpackage

// ===== design/sparse_tri_flag_tracker_top.sv =====
// -----------------------------------------------------------------------------
// sparse_tri_flag_tracker_top - sparse seen/relevant/done flag tracker
// Tagged group slots in flops, per-entry flags in a synchronous memory.
// -----------------------------------------------------------------------------
// Each request is handled in turn: the slot table is searched and the flag
// memory read on the accepting edge, and the read-modify-write of the entry,
// the slot count update and the result are done on the completing edge. A new
// request is taken once the previous one has finished, so requests do not
// overlap; the registered read of the flag memory lies ahead of the
// write-back. A result held on the output stalls the next completion until
// it is taken. After reset the flag memory is swept to zero one entry a
// cycle; no request is taken during the sweep. Groups not in the table read
// as zero; a modify that needs a new slot with the table full returns error
// and changes nothing.
// -----------------------------------------------------------------------------
module sparse_tri_flag_tracker_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [63:0] index, [66:64] set_mask, [69:67] clear_mask, [71:70] zero
	input  logic [stfl_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// [1:0] kind
	input  logic [stfl_pkg::KIND_W-1:0]      s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [0] error, [3:1] flags_read, [4] match, [7:5] zero
	output logic [stfl_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

	localparam int FW = stfl_pkg::FLAG_W;
	localparam int SW = stfl_pkg::SLOT_W;
	localparam int OW = stfl_pkg::OFF_W;
	localparam int PW = stfl_pkg::POS_W;
	localparam int TW = stfl_pkg::TAG_W;
	localparam int CW = stfl_pkg::CNT_W;
	localparam int NS = stfl_pkg::GROUP_SLOTS;

	// Request fields
	logic [stfl_pkg::INDEX_W-1:0] in_index;
	logic [FW-1:0]                in_set;
	logic [FW-1:0]                in_clr;
	logic [TW-1:0]                in_tag;
	logic [OW-1:0]                in_off;
	logic                         req_acc;

	assign in_index = s_axis_tdata[stfl_pkg::INDEX_W-1:0];
	assign in_set   = s_axis_tdata[stfl_pkg::INDEX_W +: FW];
	assign in_clr   = s_axis_tdata[stfl_pkg::INDEX_W + FW +: FW];
	assign in_tag   = in_index[stfl_pkg::INDEX_W-1:stfl_pkg::TAG_LSB];
	assign in_off   = in_index[stfl_pkg::BYTE_SH +: OW];
	assign req_acc  = s_axis_tvalid && s_axis_tready;

	// Slot table
	logic [TW-1:0] slot_tag_q   [NS];
	logic [CW-1:0] slot_cnt_q   [NS];
	logic [NS-1:0] slot_valid_q;

	// Control
	logic          busy_q;
	logic          clr_q;
	logic [PW-1:0] clr_cnt_q;
	logic          out_valid_q;
	logic [stfl_pkg::OUT_DATA_W-1:0] out_data_q;

	// Stage 1 request copy
	stfl_pkg::kind_t kind_s1;
	logic [FW-1:0]   set_s1;
	logic [FW-1:0]   clr_s1;
	logic [TW-1:0]   tag_s1;
	logic [OW-1:0]   off_s1;
	logic [SW-1:0]   slot_s1;
	logic            found_s1;
	logic            free_ok_s1;
	logic [FW-1:0]   rd_data_s1;

	// Tag search and lowest free slot
	logic          hit;
	logic [SW-1:0] hit_slot;
	logic          free_ok;
	logic [SW-1:0] free_slot;

	always_comb begin
		hit       = 1'b0;
		hit_slot  = '0;
		free_ok   = 1'b0;
		free_slot = '0;
		for (int i = NS - 1; i >= 0; i--) begin
			if (slot_valid_q[i] && (slot_tag_q[i] == in_tag)) begin
				hit      = 1'b1;
				hit_slot = SW'(i);
			end
			if (!slot_valid_q[i]) begin
				free_ok   = 1'b1;
				free_slot = SW'(i);
			end
		end
	end

	assign s_axis_tready = !busy_q && !clr_q;

	// Completion and result computation
	logic          complete;
	logic [FW-1:0] old_v;
	logic [FW-1:0] v_set;
	logic [FW-1:0] v_fin;
	logic [CW-1:0] cnt0;
	logic [CW-1:0] cnt1;
	logic [CW-1:0] cnt_fin;
	logic          do_set;
	logic          do_clr;
	logic          alloc;
	logic          free_now;
	logic          wr_en;
	logic          err_c;
	logic [FW-1:0] rd_c;
	logic          match_c;

	assign complete = busy_q && (!out_valid_q || m_axis_tready);

	always_comb begin
		old_v    = found_s1 ? rd_data_s1 : '0;
		cnt0     = found_s1 ? slot_cnt_q[slot_s1] : '0;
		do_set   = 1'b0;
		do_clr   = 1'b0;
		alloc    = 1'b0;
		free_now = 1'b0;
		wr_en    = 1'b0;
		err_c    = 1'b0;
		rd_c     = '0;
		match_c  = 1'b0;
		v_set    = old_v;
		cnt1     = cnt0;
		v_fin    = old_v;
		cnt_fin  = cnt0;
		case (kind_s1)
			stfl_pkg::KIND_READ: begin
				rd_c = old_v;
			end
			stfl_pkg::KIND_MODIFY: begin
				if (set_s1 != '0) begin
					if (!found_s1 && !free_ok_s1) begin
						err_c = 1'b1;
					end else begin
						do_set = 1'b1;
						alloc  = !found_s1;
					end
				end
				do_clr = found_s1 && (clr_s1 != '0);
				if (do_set) begin
					v_set = old_v | set_s1;
					if (old_v == '0) begin
						cnt1 = cnt0 + CW'(1);
					end
				end
				v_fin   = v_set;
				cnt_fin = cnt1;
				if (do_clr) begin
					v_fin = v_set & ~clr_s1;
					if ((v_set != '0) && (v_fin == '0) && (cnt1 != '0)) begin
						cnt_fin = cnt1 - CW'(1);
					end
					free_now = (cnt_fin == '0);
				end
				wr_en = do_set || do_clr;
			end
			stfl_pkg::KIND_CHECK: begin
				match_c = 1'b1;
				if ((set_s1 != '0) && (!found_s1 || ((old_v & set_s1) != set_s1))) begin
					match_c = 1'b0;
				end
				if (found_s1 && ((old_v & clr_s1) != '0)) begin
					match_c = 1'b0;
				end
			end
			default: begin
				rd_c = '0;
			end
		endcase
	end

	// Flag memory ports
	logic          mem_we;
	logic [PW-1:0] mem_waddr;
	logic [FW-1:0] mem_wdata;
	logic [PW-1:0] mem_raddr;

	assign mem_we    = clr_q || (complete && wr_en);
	assign mem_waddr = clr_q ? clr_cnt_q : {slot_s1, off_s1};
	assign mem_wdata = clr_q ? '0 : v_fin;
	assign mem_raddr = busy_q ? {slot_s1, off_s1} : {(hit ? hit_slot : free_slot), in_off};

	// Flag memory, one write and one registered read a cycle
	logic [FW-1:0] flag_mem [stfl_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			flag_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= flag_mem[mem_raddr];
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (req_acc) begin
			kind_s1    <= stfl_pkg::kind_t'(s_axis_tuser);
			set_s1     <= in_set;
			clr_s1     <= in_clr;
			tag_s1     <= in_tag;
			off_s1     <= in_off;
			slot_s1    <= hit ? hit_slot : free_slot;
			found_s1   <= hit;
			free_ok_s1 <= free_ok;
		end
	end

	// Slot tags
	always_ff @(posedge clk) begin
		if (complete && alloc) begin
			slot_tag_q[slot_s1] <= tag_s1;
		end
	end

	// Slot valid bits and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			for (int i = 0; i < NS; i++) begin
				slot_cnt_q[i] <= '0;
			end
		end else if (complete) begin
			if (alloc) begin
				slot_valid_q[slot_s1] <= 1'b1;
			end
			if (free_now) begin
				slot_valid_q[slot_s1] <= 1'b0;
			end
			if (wr_en) begin
				slot_cnt_q[slot_s1] <= cnt_fin;
			end
		end
	end

	// Sequencing, clearing sweep and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			clr_q       <= 1'b1;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + PW'(1);
				if (clr_cnt_q == PW'(stfl_pkg::DEPTH - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (req_acc) begin
				busy_q <= 1'b1;
			end else if (complete) begin
				busy_q <= 1'b0;
			end
			if (complete) begin
				out_valid_q <= 1'b1;
				out_data_q  <= {3'b000, match_c, rd_c, err_c};
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Checks
	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> busy_q)
		else $error("request accepted but block not busy");

	a_no_out_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !m_axis_tvalid && !busy_q)
		else $error("activity during clearing sweep");

	a_err_full: assert property (@(posedge clk) disable iff (!arst_n)
		(complete && err_c) |-> (&slot_valid_q))
		else $error("error reported with a free slot");

	a_alloc_free: assert property (@(posedge clk) disable iff (!arst_n)
		(complete && alloc) |-> !slot_valid_q[slot_s1])
		else $error("allocation of a slot in use");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		complete |=> m_axis_tvalid && !busy_q)
		else $error("completed request not presented");

endmodule

// ===== bench/tb_top.sv =====
// -----------------------------------------------------------------------------
// tb_top - self-checking bench for the sparse three-flag tracker
// Drives read, modify, check and unused-kind requests on the input stream and
// compares every result against an in-bench prediction of the slot table
// and flag store. Both stream sides idle in random bursts. A short directed
// opening covers absent groups, the table filling up, and freeing. A random
// part follows, drawn mostly from a small pool of groups and entries so that
// slots are taken and freed over and over.
// -----------------------------------------------------------------------------
module tb_top;

	localparam logic [stfl_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int N_RANDOM   = 920;
	localparam int QUIET_FROM = 770;
	localparam int N_TAGS     = 24;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic                        err;
		logic [stfl_pkg::FLAG_W-1:0] rd;
		logic                        match;
	} outcome_t;

	// Flag tracker prediction and result ordering
	class flag_scoreboard;
		bit [stfl_pkg::TAG_W-1:0]  grp_tag[stfl_pkg::GROUP_SLOTS];
		bit                        grp_valid[stfl_pkg::GROUP_SLOTS];
		int                        grp_count[stfl_pkg::GROUP_SLOTS];
		bit [stfl_pkg::FLAG_W-1:0] flag_mem[stfl_pkg::DEPTH];
		outcome_t                  awaited[$];
		int                        errors;

		function new();
			errors = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		function int find_group(bit [stfl_pkg::TAG_W-1:0] tag);
			for (int s = 0; s < stfl_pkg::GROUP_SLOTS; s++)
				if (grp_valid[s] && grp_tag[s] == tag)
					return s;
			return -1;
		endfunction

		function int lowest_free();
			for (int s = 0; s < stfl_pkg::GROUP_SLOTS; s++)
				if (!grp_valid[s])
					return s;
			return -1;
		endfunction

		// entry write, keeping the slot's count of non-empty entries
		function void put_entry(int slot, int pos, bit [stfl_pkg::FLAG_W-1:0] nv);
			if (flag_mem[pos] == 0 && nv != 0)
				grp_count[slot]++;
			else if (flag_mem[pos] != 0 && nv == 0 && grp_count[slot] > 0)
				grp_count[slot]--;
			flag_mem[pos] = nv;
		endfunction

		function void note_request(logic [stfl_pkg::KIND_W-1:0] kind,
				logic [stfl_pkg::INDEX_W-1:0] index,
				logic [stfl_pkg::FLAG_W-1:0] setm, logic [stfl_pkg::FLAG_W-1:0] clrm);
			bit [stfl_pkg::TAG_W-1:0] tag;
			int off;
			int slot;
			int pos;
			bit found;
			bit ok;
			outcome_t res;
			tag   = index[stfl_pkg::INDEX_W-1:stfl_pkg::TAG_LSB];
			off   = int'(index[stfl_pkg::TAG_LSB-1:stfl_pkg::BYTE_SH]);
			slot  = find_group(tag);
			found = (slot >= 0);
			pos   = found ? slot * stfl_pkg::FLAGS_PER_GROUP + off : 0;
			res   = '0;
			case (kind)
				stfl_pkg::KIND_READ: begin
					if (found)
						res.rd = flag_mem[pos];
				end
				stfl_pkg::KIND_MODIFY: begin
					ok = 1;
					if (setm != 0) begin
						if (!found) begin
							slot = lowest_free();
							if (slot < 0) begin
								res.err = 1;
								ok = 0;
							end else begin
								grp_valid[slot] = 1;
								grp_tag[slot]   = tag;
								grp_count[slot] = 0;
								pos = slot * stfl_pkg::FLAGS_PER_GROUP + off;
							end
						end
						if (ok)
							put_entry(slot, pos, flag_mem[pos] | setm);
					end
					// clear only applies to a group that was already present
					if (ok && found && clrm != 0) begin
						put_entry(slot, pos, flag_mem[pos] & ~clrm);
						if (grp_count[slot] == 0)
							grp_valid[slot] = 0;
					end
				end
				stfl_pkg::KIND_CHECK: begin
					res.match = 1;
					if (setm != 0 && (!found || (flag_mem[pos] & setm) != setm))
						res.match = 0;
					if (res.match && found && clrm != 0 && (flag_mem[pos] & clrm) != 0)
						res.match = 0;
				end
				default: ;
			endcase
			awaited.push_back(res);
		endfunction

		task check_result(logic [stfl_pkg::OUT_DATA_W-1:0] data);
			outcome_t want;
			if (awaited.size() == 0) begin
				report($sformatf("result %h with no request outstanding", data));
			end else begin
				want = awaited.pop_front();
				if (data[0] !== want.err)
					report($sformatf("error got %b want %b", data[0], want.err));
				if (data[3:1] !== want.rd)
					report($sformatf("flags_read got %b want %b", data[3:1], want.rd));
				if (data[4] !== want.match)
					report($sformatf("match got %b want %b", data[4], want.match));
			end
		endtask
	endclass

	logic                               clk;
	logic                               arst_n;
	logic                               s_axis_tvalid;
	logic                               s_axis_tready;
	logic [stfl_pkg::IN_DATA_W-1:0]     s_axis_tdata;
	logic [stfl_pkg::KIND_W-1:0]        s_axis_tuser;
	logic                               m_axis_tvalid;
	logic                               m_axis_tready;
	logic [stfl_pkg::OUT_DATA_W-1:0]    m_axis_tdata;

	flag_scoreboard sb;
	bit             quiet;
	int             cycles;
	logic [stfl_pkg::TAG_W-1:0] tag_pool[N_TAGS];
	logic [stfl_pkg::OFF_W-1:0] off_pool[4];

	sparse_tri_flag_tracker_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Clock
	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result capture
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// Result side back-pressure in bursts
	initial begin
		int stall;
		stall = 0;
		m_axis_tready = 0;
		forever begin
			@(negedge clk);
			if (quiet) begin
				m_axis_tready <= 1;
			end else if (stall > 0) begin
				stall--;
				m_axis_tready <= 0;
			end else if ($urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 11) - 1;
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= 1;
			end
		end
	end

	// Present one request and hold it until taken
	task send_req(logic [stfl_pkg::KIND_W-1:0] kind, logic [stfl_pkg::INDEX_W-1:0] index,
			logic [stfl_pkg::FLAG_W-1:0] setm, logic [stfl_pkg::FLAG_W-1:0] clrm);
		@(negedge clk);
		s_axis_tvalid <= 1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {2'b00, clrm, setm, index};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(kind, index, setm, clrm);
	endtask

	task idle_gap(int n);
		repeat (n) begin
			@(negedge clk);
			s_axis_tvalid <= 0;
		end
	endtask

	function logic [stfl_pkg::INDEX_W-1:0] group_index(logic [stfl_pkg::TAG_W-1:0] tag,
			logic [stfl_pkg::OFF_W-1:0] off);
		logic [31:0] rnd;
		rnd = $urandom;
		return {tag, off, rnd[stfl_pkg::BYTE_SH-1:0]};
	endfunction

	// Random request: mostly pooled groups so slots fill and free
	task send_random();
		logic [stfl_pkg::KIND_W-1:0]  kind;
		logic [stfl_pkg::INDEX_W-1:0] index;
		logic [stfl_pkg::FLAG_W-1:0]  setm;
		logic [stfl_pkg::FLAG_W-1:0]  clrm;
		int r;
		r = $urandom_range(0, 99);
		if (r < 20)
			kind = stfl_pkg::KIND_READ;
		else if (r < 60)
			kind = stfl_pkg::KIND_MODIFY;
		else if (r < 95)
			kind = stfl_pkg::KIND_CHECK;
		else
			kind = KIND_UNUSED;
		if ($urandom_range(0, 99) < 15)
			index = {$urandom, $urandom};
		else
			index = group_index(tag_pool[$urandom_range(0, N_TAGS-1)],
				off_pool[$urandom_range(0, 3)]);
		setm = stfl_pkg::FLAG_W'($urandom_range(0, 7));
		clrm = stfl_pkg::FLAG_W'($urandom_range(0, 7));
		// bias modifies towards pure clears so groups empty out
		if (kind == stfl_pkg::KIND_MODIFY && $urandom_range(0, 99) < 35)
			setm = 0;
		send_req(kind, index, setm, clrm);
	endtask

	// Stimulus
	initial begin
		logic [stfl_pkg::INDEX_W-1:0] idx;
		sb = new();
		quiet  = 0;
		cycles = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tuser  = '0;
		s_axis_tdata  = '0;

		tag_pool[0] = '0;
		tag_pool[1] = '1;
		for (int i = 2; i < N_TAGS; i++)
			tag_pool[i] = {32'($urandom), 10'(i)};
		off_pool[0] = '0;
		off_pool[1] = '1;
		off_pool[2] = stfl_pkg::OFF_W'($urandom);
		off_pool[3] = stfl_pkg::OFF_W'($urandom);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// absent group: read zero, check with empty set passes, with set fails
		idx = group_index(tag_pool[0], off_pool[0]);
		send_req(stfl_pkg::KIND_READ, idx, 3'd0, 3'd0);
		send_req(stfl_pkg::KIND_CHECK, idx, 3'd0, 3'd7);
		send_req(stfl_pkg::KIND_CHECK, idx, stfl_pkg::FLAG_SEEN, 3'd0);
		send_req(stfl_pkg::KIND_MODIFY, idx, 3'd0, 3'd7);
		// new group: clear mask ignored
		send_req(stfl_pkg::KIND_MODIFY, idx, 3'd7, 3'd7);
		send_req(stfl_pkg::KIND_READ, idx, 3'd0, 3'd0);
		send_req(stfl_pkg::KIND_CHECK, idx, 3'd7, 3'd0);
		send_req(stfl_pkg::KIND_CHECK, idx, 3'd0, stfl_pkg::FLAG_DONE);
		send_req(stfl_pkg::KIND_CHECK, idx, stfl_pkg::FLAG_SEEN | stfl_pkg::FLAG_RELEVANT,
			3'd0);
		// set and clear of the same flag ends clear
		send_req(stfl_pkg::KIND_MODIFY, idx, stfl_pkg::FLAG_DONE, stfl_pkg::FLAG_DONE);
		send_req(stfl_pkg::KIND_CHECK, idx, stfl_pkg::FLAG_SEEN | stfl_pkg::FLAG_RELEVANT,
			stfl_pkg::FLAG_DONE);
		// last entry emptied: slot freed
		send_req(stfl_pkg::KIND_MODIFY, idx, 3'd0, 3'd7);
		send_req(stfl_pkg::KIND_READ, idx, 3'd0, 3'd0);
		// all-ones index and the unused kind
		send_req(stfl_pkg::KIND_MODIFY, '1, stfl_pkg::FLAG_SEEN | stfl_pkg::FLAG_DONE,
			stfl_pkg::FLAG_RELEVANT);
		send_req(KIND_UNUSED, '1, 3'd7, 3'd7);
		// fill the table, then one allocation too many
		for (int i = 2; i <= stfl_pkg::GROUP_SLOTS; i++)
			send_req(stfl_pkg::KIND_MODIFY, group_index(tag_pool[i], off_pool[i % 4]),
				stfl_pkg::FLAG_W'($urandom_range(1, 7)),
				stfl_pkg::FLAG_W'($urandom_range(0, 7)));
		idx = group_index(tag_pool[stfl_pkg::GROUP_SLOTS+1], off_pool[1]);
		send_req(stfl_pkg::KIND_MODIFY, idx, stfl_pkg::FLAG_RELEVANT | stfl_pkg::FLAG_DONE,
			3'd0);
		send_req(stfl_pkg::KIND_READ, idx, 3'd0, 3'd0);

		// let the pipeline drain completely once
		idle_gap(1);
		while (sb.pending() != 0)
			@(posedge clk);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n >= QUIET_FROM)
				quiet = 1;
			if (!quiet && $urandom_range(0, 3) == 0)
				idle_gap($urandom_range(1, 11));
			send_random();
		end
		idle_gap(1);

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
design/stfl_pkg.sv
design/sparse_tri_flag_tracker_top.sv
bench/tb_top.sv
